// File: hdl/vf4_pkg.sv
// shared constants and types for the vollath f4 focus measure
package vf4_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 1024;

   localparam int CSR_W   = 7;
   localparam int PIXEL_W = 8;
   localparam int SCORE_W = 33;
   localparam int SUM_W   = 34;
   localparam int PROD_W  = 2 * PIXEL_W;
   localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int COL_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
   localparam int ENTRY_W = 2 * PIXEL_W;

   localparam logic [CSR_W-1:0] ROW_WIDTH_RESET = CSR_W'(16);

   // item held in the input stage, ready for the accumulate step
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
      logic [ADDR_W-1:0]  addr;
      logic               lag1;
      logic               lag2;
      logic               wr;
      logic               too_tall;
   } vf4_stage_type;

   // values read back from the row stores for the held item
   typedef struct packed {
      logic [PIXEL_W-1:0] prev;
      logic [PIXEL_W-1:0] prev_prev;
   } vf4_rows_type;

endpackage

// File: hdl/vf4_req_if.sv
// pixel input channel
interface vf4_req_if
   import vf4_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink (input valid, input pixel, input last, output ready);
endinterface

// File: hdl/vf4_rsp_if.sv
// focus score result channel
interface vf4_rsp_if
   import vf4_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] focus_score;
   logic                      too_tall;

   modport source (output valid, output focus_score, output too_tall, input ready);
   modport sink (input valid, input focus_score, input too_tall, output ready);
endinterface

// File: hdl/vollath_f4_focus_measure.sv
// Vollath F4 focus measure over a streamed 8-bit grayscale window.
//
// req_chan carries one pixel per item in row-major order, with last set on
// the final pixel of the window. rsp_chan carries one result per window:
// the 33-bit signed score (lag-one products minus lag-two products) and
// too_tall, set when the window ran past MAX_HEIGHT rows; only the first
// MAX_HEIGHT rows count then. csr_wr_en/csr_wr_data write the row width
// (0 acts as 1, values past MAX_WIDTH as MAX_WIDTH); write it only while idle.
//
// Throughput is one pixel per clock. A pixel is accepted into the input
// stage, where the row store read is registered; when it leaves that stage
// its products are added into the accumulator and the row stores are updated.
// The result register driving rsp_chan loads as the last pixel is consumed.
// Reset clears counters, sum and error flag and sets the width to 16; the
// row stores are not cleared, as every entry is written before it is used.
// When the receiver stalls, the result waits in its register and pixels keep
// flowing; req_chan.ready drops only while a last pixel waits behind a
// result not yet taken.
module vollath_f4_focus_measure
   import vf4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   vf4_req_if.sink          req_chan,
   vf4_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   logic              accept;
   logic              consume;
   logic [ADDR_W-1:0] rd_addr;
   logic              s1_valid;
   vf4_stage_type     s1;
   vf4_rows_type      rows;

   vf4_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .consume     (consume),
      .accept      (accept),
      .rd_addr     (rd_addr),
      .s1_valid    (s1_valid),
      .s1          (s1)
   );

   vf4_store u_store (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rd_addr (rd_addr),
      .consume (consume),
      .s1      (s1),
      .rows    (rows)
   );

   vf4_acc u_acc (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .rows     (rows),
      .consume  (consume),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hdl/vf4_ctrl.sv
// input stage: row width register, column and row counters, held item
module vf4_ctrl
   import vf4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   vf4_req_if.sink           req_chan,
   input  logic              csr_wr_en,
   input  logic [CSR_W-1:0]  csr_wr_data,
   input  logic              consume,
   output logic              accept,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              s1_valid,
   output vf4_stage_type     s1
);

   logic [CSR_W-1:0] row_width_ff, row_width_in;
   logic [COL_W-1:0] column_index_ff, column_index_in;
   logic [ROW_W-1:0] row_index_ff, row_index_in;
   logic             overflow_seen_ff, overflow_seen_in;
   logic             s1_valid_ff, s1_valid_in;
   vf4_stage_type    s1_ff, s1_in;

   logic [COL_W-1:0] width_eff;
   logic [COL_W-1:0] col_next;
   logic             row_ovf;

   assign req_chan.ready = !s1_valid_ff || consume;
   assign accept         = req_chan.valid && req_chan.ready;
   assign s1_valid       = s1_valid_ff;
   assign s1             = s1_ff;

   // zero acts as one, anything past the store depth as the full depth
   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (COL_W'(row_width_ff) > COL_W'(MAX_WIDTH)) begin
         width_eff = COL_W'(MAX_WIDTH);
      end else begin
         width_eff = COL_W'(row_width_ff);
      end
   end

   always_comb begin
      if (column_index_ff >= COL_W'(MAX_WIDTH)) begin
         rd_addr = ADDR_W'(MAX_WIDTH - 1);
      end else begin
         rd_addr = column_index_ff[ADDR_W-1:0];
      end
   end

   assign row_ovf  = row_index_ff >= ROW_W'(MAX_HEIGHT);
   assign col_next = column_index_ff + COL_W'(1);

   always_comb begin
      row_width_in     = csr_wr_en ? csr_wr_data : row_width_ff;
      column_index_in  = column_index_ff;
      row_index_in     = row_index_ff;
      overflow_seen_in = overflow_seen_ff;
      s1_in            = s1_ff;
      s1_valid_in      = s1_valid_ff;
      if (consume) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in       = 1'b1;
         s1_in.pixel       = req_chan.pixel;
         s1_in.last        = req_chan.last;
         s1_in.addr        = rd_addr;
         s1_in.lag1        = !row_ovf && (row_index_ff >= ROW_W'(1));
         s1_in.lag2        = !row_ovf && (row_index_ff >= ROW_W'(2));
         s1_in.wr          = !row_ovf;
         s1_in.too_tall    = overflow_seen_ff || row_ovf;
         if (col_next >= width_eff) begin
            column_index_in = '0;
            if (!row_ovf) begin
               row_index_in = row_index_ff + ROW_W'(1);
            end
         end else begin
            column_index_in = col_next;
         end
         if (req_chan.last) begin
            column_index_in  = '0;
            row_index_in     = '0;
            overflow_seen_in = 1'b0;
         end else begin
            overflow_seen_in = overflow_seen_ff || row_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= ROW_WIDTH_RESET;
         column_index_ff  <= '0;
         row_index_ff     <= '0;
         overflow_seen_ff <= 1'b0;
         s1_valid_ff      <= 1'b0;
      end else begin
         row_width_ff     <= row_width_in;
         column_index_ff  <= column_index_in;
         row_index_ff     <= row_index_in;
         overflow_seen_ff <= overflow_seen_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      column_index_ff < COL_W'(MAX_WIDTH))
      else $error("column index beyond row store depth");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_index_ff <= ROW_W'(MAX_HEIGHT))
      else $error("row index beyond height limit");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !consume |=> s1_valid_ff && $stable(s1_ff))
      else $error("held item lost or changed while not consumed");

endmodule

// File: hdl/vf4_store.sv
// two row stores packed in one memory, with forwarding of the write in flight
module vf4_store
   import vf4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              consume,
   input  vf4_stage_type     s1,
   output vf4_rows_type      rows
);

   // entry holds {two rows above, one row above}
   logic [ENTRY_W-1:0] mem [MAX_WIDTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] byp_data_ff, byp_data_in;
   logic               hit_ff, hit_in;
   logic [ENTRY_W-1:0] cur_entry;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   assign cur_entry      = hit_ff ? byp_data_ff : rd_data_ff;
   assign rows.prev      = cur_entry[PIXEL_W-1:0];
   assign rows.prev_prev = cur_entry[ENTRY_W-1:PIXEL_W];

   assign wr_en   = consume && s1.wr;
   assign wr_data = {cur_entry[PIXEL_W-1:0], s1.pixel};

   // a read issued on the same edge as a write to that column sees old data
   always_comb begin
      hit_in      = hit_ff;
      byp_data_in = byp_data_ff;
      if (accept) begin
         hit_in      = wr_en && (s1.addr == rd_addr);
         byp_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1.addr] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
   end

endmodule

// File: hdl/vf4_acc.sv
// product terms, score accumulator and result register
module vf4_acc
   import vf4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          s1_valid,
   input  vf4_stage_type s1,
   input  vf4_rows_type  rows,
   output logic          consume,
   vf4_rsp_if.source     rsp_chan
);

   logic signed [SUM_W-1:0]   score_sum_ff, score_sum_in;
   logic signed [SUM_W-1:0]   sum_next;
   logic signed [SCORE_W-1:0] focus_score_ff, focus_score_in;
   logic                      too_tall_ff, too_tall_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PROD_W-1:0]         prod1, prod2;
   logic signed [PROD_W+1:0]  term;

   assign consume = s1_valid && (!s1.last || !rsp_valid_ff || rsp_chan.ready);

   assign prod1 = s1.lag1 ? (PROD_W'(s1.pixel) * PROD_W'(rows.prev)) : '0;
   assign prod2 = s1.lag2 ? (PROD_W'(s1.pixel) * PROD_W'(rows.prev_prev)) : '0;
   assign term  = $signed({2'b00, prod1}) - $signed({2'b00, prod2});
   assign sum_next = score_sum_ff + SUM_W'(term);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.focus_score = focus_score_ff;
   assign rsp_chan.too_tall    = too_tall_ff;

   always_comb begin
      score_sum_in   = score_sum_ff;
      focus_score_in = focus_score_ff;
      too_tall_in    = too_tall_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      if (consume) begin
         score_sum_in = sum_next;
         if (s1.last) begin
            score_sum_in   = '0;
            focus_score_in = sum_next[SCORE_W-1:0];
            too_tall_in    = s1.too_tall;
            rsp_valid_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         score_sum_ff <= score_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      focus_score_ff <= focus_score_in;
      too_tall_ff    <= too_tall_in;
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      consume && s1.last |=> rsp_valid_ff && score_sum_ff == '0)
      else $error("last item did not load a result and clear the sum");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      consume && s1.last |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("result overwritten before it was taken");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the vollath f4 focus measure: streamed windows, predicted scores
`timescale 1ns / 100ps

module testbench;
   import vf4_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PIXELS = 1900;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } pixel_item_type;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      tall;
   } focus_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_W-1:0]      csr_wr_data;

   vf4_req_if pixel_chan ();
   vf4_rsp_if score_chan ();

   vollath_f4_focus_measure DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (pixel_chan),
      .rsp_chan    (score_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pixel_item_type   pixel_q [$];
   focus_result_type expected_scores [$];
   int            pixels_sent;
   int            pixels_taken;
   int            mismatches;
   int            burst_left;
   int            gap_left;
   int            hold_count;
   int            stall_cycles;
   int            stall_mode;
   logic [5:0]    mode_count;
   logic          hold_go;

   // predictor state
   logic [PIXEL_W-1:0] row_above [MAX_WIDTH];
   logic [PIXEL_W-1:0] row_two_above [MAX_WIDTH];
   bit                 above_filled [MAX_WIDTH];
   bit                 two_above_filled [MAX_WIDTH];
   longint             window_sum;
   int                 col_pos;
   int                 row_pos;
   bit                 window_tall;
   logic [CSR_W-1:0]   width_setting;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_go = 1'b0;
      pixel_chan.valid = 1'b0;
      pixel_chan.pixel = '0;
      pixel_chan.last = 1'b0;
      score_chan.ready = 1'b0;
      pixels_sent = 0;
      pixels_taken = 0;
      mismatches = 0;
      window_sum = 0;
      col_pos = 0;
      row_pos = 0;
      window_tall = 1'b0;
      width_setting = ROW_WIDTH_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int active_width(input logic [CSR_W-1:0] w);
      if (w == 0)
         return 1;
      if (w > MAX_WIDTH)
         return MAX_WIDTH;
      return int'(w);
   endfunction

   function automatic logic [CSR_W-1:0] pick_width();
      int r;
      r = $urandom_range(0, 15);
      unique case (r)
         0: return '0;
         1: return CSR_W'($urandom_range(MAX_WIDTH + 1, (1 << CSR_W) - 1));
         2: return CSR_W'(MAX_WIDTH);
         3, 4: return CSR_W'($urandom_range(9, MAX_WIDTH - 1));
         default: return CSR_W'($urandom_range(1, 8));
      endcase
   endfunction

   // lag-one product added, lag-two product taken off, rows shifted down
   task automatic accumulate_pixel(input logic [PIXEL_W-1:0] px, input logic lst);
      int               w;
      int               c;
      focus_result_type res;
      w = active_width(width_setting);
      c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
      if (row_pos >= MAX_HEIGHT) begin
         window_tall = 1'b1;
      end else begin
         if (row_pos >= 1)
            window_sum += longint'(px) * longint'(row_above[c]);
         if (row_pos >= 2)
            window_sum -= longint'(px) * longint'(row_two_above[c]);
         row_two_above[c] = row_above[c];
         two_above_filled[c] = above_filled[c];
         row_above[c] = px;
         above_filled[c] = 1'b1;
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         if (row_pos < MAX_HEIGHT)
            row_pos++;
      end else begin
         col_pos++;
      end
      if (lst) begin
         res.score = window_sum[SCORE_W-1:0];
         res.tall = window_tall;
         expected_scores.insert(expected_scores.size(), res);
         window_sum = 0;
         col_pos = 0;
         row_pos = 0;
         window_tall = 1'b0;
      end
   endtask

   // pixel driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         pixel_chan.valid <= 1'b0;
         pixel_chan.pixel <= '0;
         pixel_chan.last <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!pixel_chan.valid || pixel_chan.ready) begin
         if (pixel_chan.valid) begin
            accumulate_pixel(pixel_chan.pixel, pixel_chan.last);
            pixels_taken++;
         end
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            pixel_chan.valid <= 1'b0;
         end else if (pixel_q.size() != 0) begin
            pixel_chan.valid <= 1'b1;
            pixel_chan.pixel <= pixel_q[0].pixel;
            pixel_chan.last <= pixel_q[0].last;
            pixel_q.delete(0);
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            pixel_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver: a changing stall pattern, with one long hold-off once hold_go is set
   always @(posedge clock) begin
      if (reset) begin
         score_chan.ready <= 1'b0;
         hold_count <= 0;
         stall_mode <= 0;
         mode_count <= '0;
      end else if (hold_go && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         score_chan.ready <= 1'b0;
      end else begin
         mode_count <= mode_count + 1'b1;
         if (mode_count == 0)
            stall_mode <= $urandom_range(0, 2);
         unique case (stall_mode)
            0: score_chan.ready <= 1'b1;
            1: score_chan.ready <= 1'($urandom_range(0, 1));
            default: score_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      focus_result_type want;
      if (!reset && score_chan.valid && score_chan.ready) begin
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected result: focus_score %0d too_tall %0b", $time,
                     score_chan.focus_score, score_chan.too_tall);
            mismatches++;
         end else begin
            want = expected_scores[0];
            expected_scores.delete(0);
            if (score_chan.focus_score !== want.score) begin
               $display("%0t: focus_score expected %0d actual %0d", $time, want.score,
                        score_chan.focus_score);
               mismatches++;
            end
            if (score_chan.too_tall !== want.tall) begin
               $display("%0t: too_tall expected %0b actual %0b", $time, want.tall,
                        score_chan.too_tall);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (pixel_chan.valid && pixel_chan.ready) ||
          (score_chan.valid && score_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL vollath_f4_focus_measure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic lst);
      pixel_item_type item;
      item.pixel = px;
      item.last = lst;
      pixel_q.insert(pixel_q.size(), item);
      pixels_sent++;
   endtask

   task automatic queue_pixels(input int count, input int style, input bit close);
      logic [PIXEL_W-1:0] px;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         unique case (style)
            0: px = PIXEL_W'($urandom_range(0, 255));
            1: px = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            2: px = PIXEL_W'($urandom_range(0, 3));
            default: px = PIXEL_W'($urandom_range(252, 255));
         endcase
         send_pixel(px, close && (i == count - 1));
      end
   endtask

   // every item taken, every result in, then a wait for the input stage to drain
   task automatic wait_idle();
      @(negedge clock);
      while (pixels_taken != pixels_sent || expected_scores.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_row_width(input logic [CSR_W-1:0] v);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      width_setting = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int               random_pixels;
      int               npix;
      int               rows;
      int               split;
      int               eff;
      int               style;
      bit               tall_done;
      bit               grow_ok;
      logic [CSR_W-1:0] w;

      @(negedge clock);
      while (reset)
         @(negedge clock);

      // single-column window ending on a negative score, then a one-row window
      set_row_width(CSR_W'(1));
      @(negedge clock);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd7, 1'b1);

      // zero width behaves as one column
      set_row_width('0);
      @(negedge clock);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b1);

      // width above the maximum is clamped; partial first row scores nothing
      set_row_width('1);
      @(negedge clock);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd254, 1'b1);

      // partial last row
      set_row_width(CSR_W'(2));
      @(negedge clock);
      for (int i = 1; i <= 5; i++)
         send_pixel(PIXEL_W'(i), i == 5);

      // width shrinks mid-row so the next pixel closes the row
      set_row_width(CSR_W'(3));
      @(negedge clock);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd20, 1'b0);
      set_row_width(CSR_W'(2));
      @(negedge clock);
      send_pixel(8'd30, 1'b0);
      send_pixel(8'd40, 1'b0);
      send_pixel(8'd50, 1'b0);
      send_pixel(8'd60, 1'b1);

      // receiver holds off while short windows keep coming, so the input backs up
      set_row_width(CSR_W'(2));
      @(negedge clock);
      hold_go <= 1'b1;
      for (int i = 0; i < 8; i++)
         queue_pixels(3, $urandom_range(0, 3), 1'b1);

      random_pixels = 0;
      tall_done = 1'b0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (!tall_done && random_pixels > 800) begin
            // one column, so rows run past the height limit quickly
            set_row_width(CSR_W'($urandom_range(0, 1)));
            npix = MAX_HEIGHT + $urandom_range(1, 3);
            queue_pixels(npix, 0, 1'b1);
            random_pixels += npix;
            tall_done = 1'b1;
         end
         if ($urandom_range(0, 2) == 0)
            set_row_width(pick_width());
         eff = active_width(width_setting);
         rows = (eff > 16) ? $urandom_range(1, 3) : $urandom_range(1, 6);
         npix = (rows - 1) * eff + $urandom_range(1, eff);
         style = ($urandom_range(0, 5) > 3) ? 0 : $urandom_range(0, 3);
         if (npix > 1 && $urandom_range(0, 7) == 0) begin
            split = $urandom_range(1, npix - 1);
            queue_pixels(split, style, 1'b0);
            wait_idle();
            w = pick_width();
            // a wider row may only reach store entries already written
            grow_ok = 1'b1;
            for (int i = 0; i < active_width(w); i++)
               if (!above_filled[i] || !two_above_filled[i])
                  grow_ok = 1'b0;
            if (grow_ok)
               set_row_width(w);
            queue_pixels(npix - split, style, 1'b1);
         end else begin
            queue_pixels(npix, style, 1'b1);
         end
         random_pixels += npix;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS vollath_f4_focus_measure");
      else
         $display("FAIL vollath_f4_focus_measure");
      $finish;
   end

endmodule
